// ----- src/ljce_pkg.sv -----
// ----------------------------------------------------------------------------
// ljce_pkg
// Shared types, codes and helpers for the Lennard-Jones cutoff energy engine.
// ----------------------------------------------------------------------------
package ljce_pkg;

    localparam int MAX_ATOMS_DEF = 1024;

    // opcodes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_PARTIAL = 2'd1;
    localparam logic [1:0] OP_TOTAL   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ATOM_COUNT    = 2'd0;
    localparam logic [1:0] REG_CUTOFF_SQ_BOX = 2'd1;
    localparam logic [1:0] REG_BOX_LEN_SQ    = 2'd2;
    localparam logic [1:0] REG_OVERLAP_LIMIT = 2'd3;

    // register reset values
    localparam logic [10:0] ATOM_COUNT_RST    = 11'd0;
    localparam logic [31:0] CUTOFF_SQ_BOX_RST = 32'd351750000;
    localparam logic [31:0] BOX_LEN_SQ_RST    = 32'd3200890;
    localparam logic [31:0] OVERLAP_LIMIT_RST = 32'd29695672;

    // pair outcome codes
    localparam logic [1:0] PK_SKIP    = 2'd0;
    localparam logic [1:0] PK_TERM    = 2'd1;
    localparam logic [1:0] PK_OVERLAP = 2'd2;

    // energy range limits
    localparam logic signed [47:0] E_MAX   = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [51:0] E_MAX_W = 52'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [51:0] E_MIN_W = 52'shF_8000_0000_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         atom_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] energy;
        logic               overlap;
    } out_item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } pos_t;

    typedef struct packed {
        logic [31:0] cutoff_sq_box;
        logic [31:0] box_len_sq;
        logic [31:0] overlap_limit;
    } pair_cfg_t;

    typedef struct packed {
        logic               done;
        logic [1:0]         kind;
        logic signed [49:0] term;
    } pair_res_t;

    // saturate a widened sum to the energy range
    function automatic logic signed [47:0] sat_e(input logic signed [51:0] v);
        logic signed [47:0] r;
        if (v > E_MAX_W) begin
            r = E_MAX;
        end else if (v < E_MIN_W) begin
            r = E_MIN_W[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

// ----- src/ljce_pair.sv -----
// ----------------------------------------------------------------------------
// ljce_pair
// One pair term 4-free (sr12 - sr6) over a shared 32x32 multiplier and a
// bit-serial divider, sequenced by a small state machine.
// ----------------------------------------------------------------------------
module ljce_pair (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  ljce_pkg::pos_t      p_pos,
    input  ljce_pkg::pos_t      a_pos,
    input  ljce_pkg::pair_cfg_t cfg,
    output ljce_pkg::pair_res_t res
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SQX    = 5'd1;
    localparam logic [4:0] S_SQY    = 5'd2;
    localparam logic [4:0] S_SQZ    = 5'd3;
    localparam logic [4:0] S_CUT    = 5'd4;
    localparam logic [4:0] S_R2     = 5'd5;
    localparam logic [4:0] S_R2CHK  = 5'd6;
    localparam logic [4:0] S_DIV    = 5'd7;
    localparam logic [4:0] S_LIM    = 5'd8;
    localparam logic [4:0] S_SR4    = 5'd9;
    localparam logic [4:0] S_SR6A   = 5'd10;
    localparam logic [4:0] S_SR6B   = 5'd11;
    localparam logic [4:0] S_SR6C   = 5'd12;
    localparam logic [4:0] S_SR12A  = 5'd13;
    localparam logic [4:0] S_SR12B  = 5'd14;
    localparam logic [4:0] S_SR12C  = 5'd15;
    localparam logic [4:0] S_SR12D  = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;

    localparam logic [47:0] R2_FLOOR = 48'h00_0000_0100_0000;

    logic [4:0]  state_reg, state_next;
    logic [31:0] mx_reg, mx_next, my_reg, my_next, mz_reg, mz_next;
    logic [63:0] prod_reg;
    logic [63:0] d2_reg, d2_next;
    logic [31:0] s_reg, s_next;
    logic [47:0] r2_reg, r2_next;
    logic [47:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] sr2_reg, sr2_next;
    logic [23:0] l_reg, l_next;
    logic [49:0] acc_reg, acc_next;
    logic [47:0] sr6_reg, sr6_next;
    logic [47:0] sr12_reg, sr12_next;
    ljce_pkg::pair_res_t res_reg, res_next;

    logic [31:0] mul_a, mul_b;
    logic [31:0] dx, dy, dz;
    logic [63:0] d2_full;
    logic [47:0] r2_w;
    logic [48:0] rs;
    logic [49:0] sr12_w;

    assign res = res_reg;

    // wrapped differences give the minimum image directly
    assign dx = p_pos.x - a_pos.x;
    assign dy = p_pos.y - a_pos.y;
    assign dz = p_pos.z - a_pos.z;
    assign d2_full = d2_reg + prod_reg;
    assign r2_w    = prod_reg[63:16];
    assign rs      = {rem_reg, 1'b0};
    assign sr12_w  = acc_reg + {26'd0, prod_reg[47:24]};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQX:   begin mul_a = mx_reg; mul_b = mx_reg; end
            S_SQY:   begin mul_a = my_reg; mul_b = my_reg; end
            S_SQZ:   begin mul_a = mz_reg; mul_b = mz_reg; end
            S_R2:    begin mul_a = s_reg; mul_b = cfg.box_len_sq; end
            S_SR4:   begin mul_a = sr2_reg; mul_b = sr2_reg; end
            S_SR6A:  begin mul_a = 32'(prod_reg[63:48]); mul_b = sr2_reg; end
            S_SR6B:  begin mul_a = 32'(l_reg); mul_b = sr2_reg; end
            S_SR12A: begin mul_a = 32'(sr6_reg[47:24]); mul_b = 32'(sr6_reg[47:24]); end
            S_SR12B: begin mul_a = 32'(sr6_reg[47:24]); mul_b = 32'(sr6_reg[23:0]); end
            S_SR12C: begin mul_a = 32'(sr6_reg[23:0]); mul_b = 32'(sr6_reg[23:0]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        mz_next    = mz_reg;
        d2_next    = d2_reg;
        s_next     = s_reg;
        r2_next    = r2_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        sr2_next   = sr2_reg;
        l_next     = l_reg;
        acc_next   = acc_reg;
        sr6_next   = sr6_reg;
        sr12_next  = sr12_reg;
        res_next   = res_reg;
        res_next.done = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    mx_next = dx[31] ? (~dx + 32'd1) : dx;
                    my_next = dy[31] ? (~dy + 32'd1) : dy;
                    mz_next = dz[31] ? (~dz + 32'd1) : dz;
                    if ((dx == '0) && (dy == '0) && (dz == '0)) begin
                        res_next.done = 1'b1;
                        res_next.kind = ljce_pkg::PK_SKIP;
                    end else begin
                        state_next = S_SQX;
                    end
                end
            end
            S_SQX: state_next = S_SQY;
            S_SQY: begin
                d2_next    = prod_reg;
                state_next = S_SQZ;
            end
            S_SQZ: begin
                d2_next    = d2_full;
                state_next = S_CUT;
            end
            // cutoff test on the exact squared distance
            S_CUT: begin
                if (d2_full[63:32] >= cfg.cutoff_sq_box) begin
                    res_next.done = 1'b1;
                    res_next.kind = ljce_pkg::PK_SKIP;
                    state_next    = S_IDLE;
                end else begin
                    s_next     = d2_full[63:32];
                    state_next = S_R2;
                end
            end
            S_R2: state_next = S_R2CHK;
            // r2 at or below 2^24 gives sr2 beyond any 32-bit limit
            S_R2CHK: begin
                if (r2_w <= R2_FLOOR) begin
                    res_next.done = 1'b1;
                    res_next.kind = ljce_pkg::PK_OVERLAP;
                    state_next    = S_IDLE;
                end else begin
                    r2_next    = r2_w;
                    rem_next   = R2_FLOOR;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            // restoring division of 2^56 by r2, one quotient bit a cycle
            S_DIV: begin
                if (rs >= {1'b0, r2_reg}) begin
                    rem_next = 48'(rs - {1'b0, r2_reg});
                    q_next   = {q_reg[30:0], 1'b1};
                end else begin
                    rem_next = rs[47:0];
                    q_next   = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = S_LIM;
                end
            end
            S_LIM: begin
                if (q_reg > cfg.overlap_limit) begin
                    res_next.done = 1'b1;
                    res_next.kind = ljce_pkg::PK_OVERLAP;
                    state_next    = S_IDLE;
                end else begin
                    sr2_next   = q_reg;
                    state_next = S_SR4;
                end
            end
            S_SR4: state_next = S_SR6A;
            S_SR6A: begin
                l_next     = prod_reg[47:24];
                state_next = S_SR6B;
            end
            S_SR6B: begin
                acc_next   = {2'b00, prod_reg[47:0]};
                state_next = S_SR6C;
            end
            S_SR6C: begin
                sr6_next   = 48'(acc_reg + {18'd0, prod_reg[55:24]});
                state_next = S_SR12A;
            end
            // sr12 from the square of sr6 split in halves
            S_SR12A: begin
                if (sr6_reg[47:36] != '0) begin
                    sr12_next  = ljce_pkg::E_MAX;
                    state_next = S_FIN;
                end else begin
                    state_next = S_SR12B;
                end
            end
            S_SR12B: begin
                acc_next   = {prod_reg[25:0], 24'd0};
                state_next = S_SR12C;
            end
            S_SR12C: begin
                acc_next   = acc_reg + {prod_reg[48:0], 1'b0};
                state_next = S_SR12D;
            end
            S_SR12D: begin
                if (sr12_w > {2'b00, ljce_pkg::E_MAX}) begin
                    sr12_next = ljce_pkg::E_MAX;
                end else begin
                    sr12_next = sr12_w[47:0];
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                res_next.done = 1'b1;
                res_next.kind = ljce_pkg::PK_TERM;
                res_next.term = $signed({2'b00, sr12_reg}) - $signed({2'b00, sr6_reg});
                state_next    = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            res_reg.done <= 1'b0;
        end else begin
            state_reg    <= state_next;
            res_reg.done <= res_next.done;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg     <= mul_a * mul_b;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        mz_reg       <= mz_next;
        d2_reg       <= d2_next;
        s_reg        <= s_next;
        r2_reg       <= r2_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        sr2_reg      <= sr2_next;
        l_reg        <= l_next;
        acc_reg      <= acc_next;
        sr6_reg      <= sr6_next;
        sr12_reg     <= sr12_next;
        res_reg.kind <= res_next.kind;
        res_reg.term <= res_next.term;
    end

endmodule

// ----- src/lj_cutoff_energy_engine_top.sv -----
// ----------------------------------------------------------------------------
// lj_cutoff_energy_engine_top
// Lennard-Jones energy engine with minimum-image cutoff over a position store.
// ----------------------------------------------------------------------------
// A load word (opcode 0) writes one atom and leaves the input ready. A
// partial-energy word (opcode 1) walks the first atom_count stored atoms, one
// pair at a time through a single pair unit built on one shared 32x32
// multiplier and a bit-serial divider: a pair on the test position or outside
// the cutoff ends early, one inside it runs the 32-step divide, which
// dominates, and the word holds the input until the walk is done. A
// total-energy word (opcode 2) repeats that walk for every stored atom, and
// either walk stops early on the first overlap. The block takes no word while
// a query is in flight; one finished result may wait in the output register,
// and a second one holds the input until the output register is free.
module lj_cutoff_energy_engine_top #(
    parameter int MAX_ATOMS = ljce_pkg::MAX_ATOMS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ljce_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ljce_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W = $clog2(MAX_ATOMS + 1);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_RDI  = 3'd1;
    localparam logic [2:0] T_LDI  = 3'd2;
    localparam logic [2:0] T_RDJ  = 3'd3;
    localparam logic [2:0] T_STJ  = 3'd4;
    localparam logic [2:0] T_WTJ  = 3'd5;
    localparam logic [2:0] T_EMIT = 3'd6;

    ljce_pkg::pos_t position_store [MAX_ATOMS];

    logic [2:0]          state_reg, state_next;
    logic                total_reg, total_next;
    ljce_pkg::pos_t      p_reg, p_next;
    ljce_pkg::pos_t      rd_data_reg;
    logic [CNT_W-1:0]    i_reg, i_next, j_reg, j_next;
    logic signed [47:0]  sum_reg, sum_next, tot_reg, tot_next;
    ljce_pkg::out_item_t res_reg, res_next;
    ljce_pkg::out_item_t out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    logic [10:0] atom_count_reg;
    logic [31:0] cutoff_reg, box_reg, limit_reg;

    logic                mem_we, mem_re;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [CNT_W-1:0]    eff_count;
    logic                pair_start;
    ljce_pkg::pair_cfg_t pair_cfg;
    ljce_pkg::pair_res_t pair_res;
    ljce_pkg::pos_t      in_pos;
    logic                s_fire, last_j, last_i;
    logic signed [47:0]  sum_w, part_w, tot_w;

    assign s_ready   = (state_reg == T_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    assign in_pos.x = s_data.pos_x;
    assign in_pos.y = s_data.pos_y;
    assign in_pos.z = s_data.pos_z;

    // counts above the store depth act as the depth
    assign eff_count = (32'(atom_count_reg) > 32'(MAX_ATOMS)) ?
                       CNT_W'(MAX_ATOMS) : CNT_W'(atom_count_reg);

    assign last_j = ({1'b0, j_reg} + 1'b1) == {1'b0, eff_count};
    assign last_i = ({1'b0, i_reg} + 1'b1) == {1'b0, eff_count};

    assign wr_addr = AW'(32'(s_data.atom_index));
    assign rd_addr = (state_reg == T_RDI) ? i_reg[AW-1:0] : j_reg[AW-1:0];
    assign mem_we  = s_fire && (s_data.opcode == ljce_pkg::OP_LOAD) &&
                     (32'(s_data.atom_index) < 32'(MAX_ATOMS));
    assign mem_re  = (state_reg == T_RDI) || (state_reg == T_RDJ);

    assign pair_cfg.cutoff_sq_box = cutoff_reg;
    assign pair_cfg.box_len_sq    = box_reg;
    assign pair_cfg.overlap_limit = limit_reg;
    assign pair_start = (state_reg == T_STJ);

    // running sums, saturated after every step
    assign sum_w  = (pair_res.kind == ljce_pkg::PK_TERM) ?
                    ljce_pkg::sat_e(52'(sum_reg) + 52'(pair_res.term)) : sum_reg;
    assign part_w = ljce_pkg::sat_e(52'(sum_w) <<< 2);
    assign tot_w  = ljce_pkg::sat_e(52'(tot_reg) + 52'(part_w));

    ljce_pair u_pair (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pair_start),
        .p_pos   (p_reg),
        .a_pos   (rd_data_reg),
        .cfg     (pair_cfg),
        .res     (pair_res)
    );

    // position store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            position_store[wr_addr] <= in_pos;
        end
        if (mem_re) begin
            rd_data_reg <= position_store[rd_addr];
        end
    end

    // query sequencer
    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        p_next       = p_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        sum_next     = sum_reg;
        tot_next     = tot_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            T_IDLE: begin
                if (s_fire) begin
                    case (s_data.opcode)
                        ljce_pkg::OP_PARTIAL: begin
                            total_next = 1'b0;
                            p_next     = in_pos;
                            j_next     = '0;
                            sum_next   = '0;
                            res_next   = '0;
                            state_next = (eff_count == '0) ? T_EMIT : T_RDJ;
                        end
                        ljce_pkg::OP_TOTAL: begin
                            total_next = 1'b1;
                            i_next     = '0;
                            tot_next   = '0;
                            res_next   = '0;
                            state_next = (eff_count == '0) ? T_EMIT : T_RDI;
                        end
                        default: state_next = T_IDLE;
                    endcase
                end
            end
            T_RDI: state_next = T_LDI;
            T_LDI: begin
                p_next     = rd_data_reg;
                j_next     = '0;
                sum_next   = '0;
                state_next = T_RDJ;
            end
            T_RDJ: state_next = T_STJ;
            T_STJ: state_next = T_WTJ;
            T_WTJ: begin
                if (pair_res.done) begin
                    if (pair_res.kind == ljce_pkg::PK_OVERLAP) begin
                        res_next.energy  = '0;
                        res_next.overlap = 1'b1;
                        state_next       = T_EMIT;
                    end else if (!last_j) begin
                        sum_next   = sum_w;
                        j_next     = j_reg + 1'b1;
                        state_next = T_RDJ;
                    end else if (!total_reg) begin
                        res_next.energy  = part_w;
                        res_next.overlap = 1'b0;
                        state_next       = T_EMIT;
                    end else if (last_i) begin
                        res_next.energy  = tot_w;
                        res_next.overlap = 1'b0;
                        state_next       = T_EMIT;
                    end else begin
                        tot_next   = tot_w;
                        i_next     = i_reg + 1'b1;
                        state_next = T_RDI;
                    end
                end
            end
            // hand the result to the output register once it is free
            T_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            m_valid_reg    <= 1'b0;
            atom_count_reg <= ljce_pkg::ATOM_COUNT_RST;
            cutoff_reg     <= ljce_pkg::CUTOFF_SQ_BOX_RST;
            box_reg        <= ljce_pkg::BOX_LEN_SQ_RST;
            limit_reg      <= ljce_pkg::OVERLAP_LIMIT_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ljce_pkg::REG_ATOM_COUNT:    atom_count_reg <= cfg_data[10:0];
                    ljce_pkg::REG_CUTOFF_SQ_BOX: cutoff_reg     <= cfg_data;
                    ljce_pkg::REG_BOX_LEN_SQ:    box_reg        <= cfg_data;
                    ljce_pkg::REG_OVERLAP_LIMIT: limit_reg      <= cfg_data;
                    default:                     limit_reg      <= limit_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        p_reg     <= p_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        sum_reg   <= sum_next;
        tot_reg   <= tot_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // an overlapped result always carries zero energy
    a_overlap_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overlap |-> m_data.energy == '0)
        else $error("overlap result with nonzero energy");

    // a load finishes in the cycle it is taken
    a_load_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == ljce_pkg::OP_LOAD) |=> s_ready)
        else $error("load word held the input channel");

    // the pair unit only answers while the sequencer waits for it
    a_pair_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_res.done |-> state_reg == T_WTJ)
        else $error("pair result outside the wait state");

endmodule
